// ===== rtl/pss_pkg.sv =====
package pss_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int OPCODE_W = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT_AT     = 3'd0,
      OP_INSERT_SORTED = 3'd1,
      OP_ERASE_AT      = 3'd2,
      OP_REMOVE_ALL    = 3'd3,
      OP_GET           = 3'd4,
      OP_SET           = 3'd5,
      OP_FIND          = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     re;
      idx_type  raddr;
      logic     we;
      idx_type  waddr;
      word_type wdata;
   } ram_req_type;

endpackage

// ===== rtl/pss_req_if.sv =====
interface pss_req_if import pss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

// ===== rtl/pss_rsp_if.sv =====
interface pss_rsp_if import pss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    result_position;
   logic [VALUE_W-1:0]  result_value;
   logic [POS_W-1:0]    removed_count;
   logic [POS_W-1:0]    occupancy;

   modport source (output valid, output status, output result_position, output result_value,
                   output removed_count, output occupancy, input ready);
   modport sink   (input valid, input status, input result_position, input result_value,
                   input removed_count, input occupancy, output ready);
endinterface

// ===== rtl/pss_ram.sv =====
module pss_ram import pss_pkg::*; (
   input  logic        clock,
   input  ram_req_type ram_req,
   output word_type    rdata
);

   word_type mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata <= mem[ram_req.raddr];
      end
   end

endmodule

// ===== rtl/positional_sequence_store_core.sv =====
// Steps to result valid: set and rejected transactions go straight from idle to done; get
// reads one word; find and remove_all scan up to the occupancy; erase_at moves the entries
// above position down, insert_at those from position up; insert_sorted scans, then shifts.
// One transaction at a time: the next is accepted in the cycle after the result is loaded;
// the slowest is insert_sorted at the front, bounded by the single memory port.
// Reset: synchronous, clears entry count and handshake state; memory contents are kept.
module positional_sequence_store_core import pss_pkg::*; (
   input logic        clock,
   input logic        reset,
   pss_req_if.sink    req_chan,
   pss_rsp_if.source  rsp_chan
);

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   cnt_type     pos_ff, pos_in;
   word_type    word_ff, word_in;
   cnt_type     rd_ff, rd_in;
   cnt_type     lim_ff, lim_in;
   logic        pend_ff, pend_in;
   idx_type     pend_addr_ff, pend_addr_in;
   cnt_type     kept_ff, kept_in;
   cnt_type     removed_ff, removed_in;
   cnt_type     count_ff, count_in;
   status_type  status_ff, status_in;
   cnt_type     rpos_ff, rpos_in;
   word_type    rval_ff, rval_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]    rsp_rpos_ff, rsp_rpos_in;
   logic [VALUE_W-1:0]  rsp_rval_ff, rsp_rval_in;
   logic [POS_W-1:0]    rsp_removed_ff, rsp_removed_in;
   logic [POS_W-1:0]    rsp_occ_ff, rsp_occ_in;

   ram_req_type ram_req;
   word_type    rdata;

   op_type     req_op;
   logic       pos_beyond, pos_outside, is_full;
   logic       hit, notless, stop, scan_issue, scan_end, shift_issue, out_free;
   idx_type    up_addr;

   pss_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (rdata)
   );

   assign req_op      = op_type'(req_chan.opcode);
   assign pos_beyond  = CMP_W'(req_chan.position) > CMP_W'(count_ff);
   assign pos_outside = CMP_W'(req_chan.position) >= CMP_W'(count_ff);
   assign is_full     = count_ff == CNT_W'(CAPACITY);

   assign hit         = pend_ff && (rdata == word_ff);
   assign notless     = pend_ff && !(word_ff > rdata);
   assign stop        = ((op_ff == OP_FIND) && hit) || ((op_ff == OP_INSERT_SORTED) && notless);
   assign scan_issue  = !stop && (rd_ff < lim_ff);
   assign scan_end    = !pend_ff && !(rd_ff < lim_ff);
   assign shift_issue = rd_ff > pos_ff;
   assign up_addr     = IDX_W'(rd_ff - CNT_W'(1));
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready           = state_ff == ST_IDLE;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.result_position = rsp_rpos_ff;
   assign rsp_chan.result_value    = rsp_rval_ff;
   assign rsp_chan.removed_count   = rsp_removed_ff;
   assign rsp_chan.occupancy       = rsp_occ_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               unique case (req_op)
                  OP_INSERT_AT:     state_in = (pos_beyond || is_full) ? ST_DONE : ST_SHIFT;
                  OP_INSERT_SORTED: state_in = is_full ? ST_DONE : ST_SCAN;
                  OP_ERASE_AT,
                  OP_GET:           state_in = pos_outside ? ST_DONE : ST_SCAN;
                  OP_REMOVE_ALL,
                  OP_FIND:          state_in = ST_SCAN;
                  default:          state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            unique case (op_ff)
               OP_FIND:          if (hit || scan_end) state_in = ST_DONE;
               OP_INSERT_SORTED: if (notless || scan_end) state_in = ST_SHIFT;
               OP_GET:           if (pend_ff) state_in = ST_DONE;
               default:          if (scan_end) state_in = ST_DONE;
            endcase
         end
         ST_SHIFT: if (!pend_ff && !shift_issue) state_in = ST_PLACE;
         ST_PLACE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in          = op_ff;
      pos_in         = pos_ff;
      word_in        = word_ff;
      rd_in          = rd_ff;
      lim_in         = lim_ff;
      pend_in        = 1'b0;
      pend_addr_in   = pend_addr_ff;
      kept_in        = kept_ff;
      removed_in     = removed_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      rpos_in        = rpos_ff;
      rval_in        = rval_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_rpos_in    = rsp_rpos_ff;
      rsp_rval_in    = rsp_rval_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_occ_in     = rsp_occ_ff;
      ram_req        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in      = req_op;
               pos_in     = CNT_W'(req_chan.position);
               word_in    = DATA_WIDTH'(req_chan.value);
               kept_in    = '0;
               removed_in = '0;
               status_in  = STAT_OK;
               rpos_in    = '0;
               rval_in    = '0;
               lim_in     = count_ff;
               rd_in      = '0;
               unique case (req_op)
                  OP_INSERT_AT: begin
                     if (pos_beyond) begin
                        status_in = STAT_RANGE;
                     end else if (is_full) begin
                        status_in = STAT_FULL;
                     end
                     rd_in = count_ff;
                  end
                  OP_INSERT_SORTED: begin
                     if (is_full) begin
                        status_in = STAT_FULL;
                     end
                  end
                  OP_ERASE_AT: begin
                     if (pos_outside) begin
                        status_in = STAT_RANGE;
                     end
                     rd_in = CNT_W'(req_chan.position) + CNT_W'(1);
                  end
                  OP_GET: begin
                     if (pos_outside) begin
                        status_in = STAT_RANGE;
                     end
                     rd_in  = CNT_W'(req_chan.position);
                     lim_in = CNT_W'(req_chan.position) + CNT_W'(1);
                  end
                  OP_SET: begin
                     if (pos_outside) begin
                        status_in = STAT_RANGE;
                     end else begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = IDX_W'(req_chan.position);
                        ram_req.wdata = DATA_WIDTH'(req_chan.value);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            ram_req.re    = scan_issue;
            ram_req.raddr = IDX_W'(rd_ff);
            pend_in       = scan_issue;
            pend_addr_in  = IDX_W'(rd_ff);
            if (scan_issue) begin
               rd_in = rd_ff + CNT_W'(1);
            end
            unique case (op_ff)
               OP_FIND: begin
                  if (hit) begin
                     rpos_in = CNT_W'(pend_addr_ff);
                  end else if (scan_end) begin
                     status_in = STAT_MISSING;
                  end
               end
               OP_INSERT_SORTED: begin
                  if (notless) begin
                     pos_in = CNT_W'(pend_addr_ff);
                     rd_in  = count_ff;
                  end else if (scan_end) begin
                     pos_in = count_ff;
                     rd_in  = count_ff;
                  end
               end
               OP_REMOVE_ALL: begin
                  if (hit) begin
                     removed_in = removed_ff + CNT_W'(1);
                  end else if (pend_ff) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = IDX_W'(kept_ff);
                     ram_req.wdata = rdata;
                     kept_in       = kept_ff + CNT_W'(1);
                  end
                  if (scan_end) begin
                     count_in = kept_ff;
                  end
               end
               OP_ERASE_AT: begin
                  if (pend_ff) begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = pend_addr_ff - IDX_W'(1);
                     ram_req.wdata = rdata;
                  end
                  if (scan_end) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               OP_GET: begin
                  if (pend_ff) begin
                     rval_in = rdata;
                  end
               end
               default: ;
            endcase
         end
         ST_SHIFT: begin
            ram_req.re    = shift_issue;
            ram_req.raddr = up_addr;
            pend_in       = shift_issue;
            pend_addr_in  = up_addr;
            if (shift_issue) begin
               rd_in = rd_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               ram_req.we    = 1'b1;
               ram_req.waddr = pend_addr_ff + IDX_W'(1);
               ram_req.wdata = rdata;
            end
         end
         ST_PLACE: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = IDX_W'(pos_ff);
            ram_req.wdata = word_ff;
            count_in      = count_ff + CNT_W'(1);
            rpos_in       = pos_ff;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_rpos_in    = POS_W'(rpos_ff);
               rsp_rval_in    = VALUE_W'(rval_ff);
               rsp_removed_in = POS_W'(removed_ff);
               rsp_occ_in     = POS_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      word_ff        <= word_in;
      rd_ff          <= rd_in;
      lim_ff         <= lim_in;
      pend_addr_ff   <= pend_addr_in;
      kept_ff        <= kept_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rpos_ff        <= rpos_in;
      rval_ff        <= rval_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rpos_ff    <= rsp_rpos_in;
      rsp_rval_ff    <= rsp_rval_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

endmodule

// ===== test/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_NONE = 3'd7;
   localparam int PLAN_ITEMS  = 1200;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 8;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [POS_W-1:0]    position;
      logic [VALUE_W-1:0]  value;
   } seq_cmd_type;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   at;
      logic [VALUE_W-1:0] word;
      logic [POS_W-1:0]   removed;
      logic [POS_W-1:0]   held;
   } seq_outcome_type;

   typedef struct packed {
      logic [CAPACITY-1:0][DATA_WIDTH-1:0] slot;
      logic [7:0]                          held;
   } seq_store_type;

   typedef struct packed {
      seq_cmd_type cmd;
      logic        drain;
      logic        hold;
      logic [6:0]  idle_pct;
      logic [6:0]  stall_pct;
   } planned_cmd_type;

   logic clock = 1'b0;
   logic reset;
   logic req_fire = 1'b0;

   pss_req_if req_if ();
   pss_rsp_if rsp_if ();

   seq_store_type   plan_store = '0;
   seq_store_type   live_store = '0;
   planned_cmd_type cmd_backlog[$];
   seq_outcome_type pending_outcomes[$];

   int planned;
   int recv_stall_pct;
   int hold_tokens;
   int holds_done;
   int hold_left;
   int quiet_cycles;
   int mismatches;
   int accepted;
   int peak_held;
   int status_seen[4];

   positional_sequence_store_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   function automatic void place_word(inout seq_store_type s, input int at, input word_type w);
      int k;
      for (k = s.held; k > at; k--) s.slot[k] = s.slot[k-1];
      s.slot[at] = w;
      s.held++;
   endfunction

   function automatic seq_outcome_type sequence_step(inout seq_store_type s,
                                                     input seq_cmd_type c);
      seq_outcome_type o;
      word_type        w;
      int              k;
      int              kept;
      o = '0;
      o.status = STAT_OK;
      w = c.value[DATA_WIDTH-1:0];
      case (c.opcode)
         OP_INSERT_AT: begin
            if (c.position > s.held) begin
               o.status = STAT_RANGE;
            end else if (s.held >= CAPACITY) begin
               o.status = STAT_FULL;
            end else begin
               place_word(s, c.position, w);
               o.at = c.position;
            end
         end
         OP_INSERT_SORTED: begin
            if (s.held >= CAPACITY) begin
               o.status = STAT_FULL;
            end else begin
               k = 0;
               while (k < s.held && w > s.slot[k]) k++;
               place_word(s, k, w);
               o.at = k;
            end
         end
         OP_ERASE_AT: begin
            if (c.position >= s.held) begin
               o.status = STAT_RANGE;
            end else begin
               for (k = c.position; k + 1 < s.held; k++) s.slot[k] = s.slot[k+1];
               s.held--;
            end
         end
         OP_REMOVE_ALL: begin
            kept = 0;
            for (k = 0; k < s.held; k++) begin
               if (s.slot[k] == w) begin
                  o.removed++;
               end else begin
                  s.slot[kept] = s.slot[k];
                  kept++;
               end
            end
            s.held = kept;
         end
         OP_GET: begin
            if (c.position >= s.held) o.status = STAT_RANGE;
            else o.word = s.slot[c.position];
         end
         OP_SET: begin
            if (c.position >= s.held) o.status = STAT_RANGE;
            else s.slot[c.position] = w;
         end
         OP_FIND: begin
            o.status = STAT_MISSING;
            for (k = s.held - 1; k >= 0; k--) begin
               if (s.slot[k] == w) begin
                  o.status = STAT_OK;
                  o.at = k;
               end
            end
         end
         default: ;
      endcase
      o.held = s.held[POS_W-1:0];
      return o;
   endfunction

   task automatic add_cmd(input logic [OPCODE_W-1:0] opc, input int pos, input word_type val);
      planned_cmd_type p;
      seq_outcome_type ignored;
      p.cmd.opcode = opc;
      p.cmd.position = pos[POS_W-1:0];
      p.cmd.value = val;
      p.drain = (planned % 400 == 150);
      p.hold = (planned % 400 == 350);
      case ((planned / 100) % 4)
         1: begin
            p.idle_pct = 60;
            p.stall_pct = 0;
         end
         2: begin
            p.idle_pct = 0;
            p.stall_pct = 60;
         end
         3: begin
            p.idle_pct = 8;
            p.stall_pct = 8;
         end
         default: begin
            p.idle_pct = 0;
            p.stall_pct = 0;
         end
      endcase
      ignored = sequence_step(plan_store, p.cmd);
      cmd_backlog.push_back(p);
      planned++;
   endtask

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return word_type'($urandom_range(0, 7));
      if (r < 55 && plan_store.held != 0)
         return plan_store.slot[$urandom_range(0, plan_store.held - 1)];
      if (r < 65) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            default: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
         endcase
      end
      return word_type'($urandom);
   endfunction

   function automatic int pick_position(input bit for_insert);
      int r;
      int top;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom_range(0, 127);
      if (r < 14 || plan_store.held == 0) return plan_store.held;
      top = for_insert ? plan_store.held : plan_store.held - 1;
      return $urandom_range(0, top);
   endfunction

   task automatic add_insert();
      logic [OPCODE_W-1:0] opc;
      opc = $urandom_range(0, 1) ? OP_INSERT_SORTED : OP_INSERT_AT;
      add_cmd(opc, pick_position(1'b1), pick_value());
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin : driver
      planned_cmd_type next;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (cmd_backlog.size() == 0 ||
             (cmd_backlog[0].drain && pending_outcomes.size() != 0) ||
             $urandom_range(0, 99) < cmd_backlog[0].idle_pct) begin
            req_if.valid <= 1'b0;
         end else begin
            next = cmd_backlog.pop_front();
            req_if.valid <= 1'b1;
            req_if.opcode <= next.cmd.opcode;
            req_if.position <= next.cmd.position;
            req_if.value <= next.cmd.value;
            recv_stall_pct <= next.stall_pct;
            if (next.hold) hold_tokens <= hold_tokens + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_tokens != holds_done) begin
         rsp_if.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      seq_cmd_type     cmd;
      seq_outcome_type want;
      seq_outcome_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            cmd.opcode = req_if.opcode;
            cmd.position = req_if.position;
            cmd.value = req_if.value;
            want = sequence_step(live_store, cmd);
            pending_outcomes.push_back(want);
            accepted++;
            if (live_store.held > peak_held) peak_held = live_store.held;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.status = status_type'(rsp_if.status);
            got.at = rsp_if.result_position;
            got.word = rsp_if.result_value;
            got.removed = rsp_if.removed_count;
            got.held = rsp_if.occupancy;
            if (pending_outcomes.size() == 0) begin
               $display("%0t ns: response with nothing outstanding, expected none, actual %h",
                        $time, got);
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("status", want.status, got.status);
               check_field("result_position", want.at, got.at);
               check_field("result_value", want.word, got.word);
               check_field("removed_count", want.removed, got.removed);
               check_field("occupancy", want.held, got.held);
               status_seen[want.status]++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int                  target;
      int                  b_share;
      word_type            a;
      word_type            b;
      logic [OPCODE_W-1:0] opc;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_GET;
      req_if.position = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;

      add_cmd(OP_GET, 0, '0);
      add_cmd(OP_ERASE_AT, 0, '0);
      add_cmd(OP_SET, 0, 32'h1);
      add_cmd(OP_FIND, 0, '0);
      add_cmd(OP_REMOVE_ALL, 0, 32'd5);
      add_cmd(OP_INSERT_AT, 1, 32'd9);
      add_cmd(OP_INSERT_AT, 127, '1);
      add_cmd(OP_INSERT_AT, 0, '0);
      add_cmd(OP_INSERT_AT, 1, '1);
      add_cmd(OP_INSERT_SORTED, 0, 32'h8000_0000);
      add_cmd(OP_INSERT_SORTED, 127, '0);
      add_cmd(OP_INSERT_SORTED, 0, '1);
      add_cmd(OP_INSERT_AT, 2, 32'h1234_5678);
      add_cmd(OP_GET, 5, '0);
      add_cmd(OP_GET, 6, '0);
      add_cmd(OP_SET, 1, 32'h5555_5555);
      add_cmd(OP_FIND, 0, '1);
      add_cmd(OP_FIND, 0, 32'hdead_beef);
      add_cmd(OP_REMOVE_ALL, 0, '1);
      add_cmd(OP_REMOVE_ALL, 0, 32'h7777);
      add_cmd(OP_ERASE_AT, 0, '0);
      add_cmd(OP_NONE, 127, '1);
      add_cmd(OP_ERASE_AT, 127, '0);
      add_cmd(OP_SET, 127, '1);

      while (planned < PLAN_ITEMS) begin
         case ($urandom_range(0, 3))
            0: begin
               while (plan_store.held < CAPACITY) add_insert();
               repeat ($urandom_range(1, 3)) add_insert();
            end
            1: begin
               a = pick_value();
               b = pick_value();
               b_share = $urandom_range(0, 2) * 20;
               target = $urandom_range(plan_store.held, CAPACITY);
               while (plan_store.held < target) begin
                  opc = $urandom_range(0, 1) ? OP_INSERT_SORTED : OP_INSERT_AT;
                  add_cmd(opc, pick_position(1'b1),
                          ($urandom_range(0, 99) < b_share) ? b : a);
               end
               add_cmd(OP_FIND, pick_position(1'b0), b);
               add_cmd(OP_REMOVE_ALL, pick_position(1'b0), a);
            end
            2: begin
               target = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
               while (plan_store.held > target) begin
                  if ($urandom_range(0, 4) == 0)
                     add_cmd(OP_REMOVE_ALL, pick_position(1'b0),
                             plan_store.slot[$urandom_range(0, plan_store.held - 1)]);
                  else
                     add_cmd(OP_ERASE_AT, pick_position(1'b0), pick_value());
               end
            end
            default: begin
               repeat (40) begin
                  opc = $urandom_range(0, 7);
                  add_cmd(opc, pick_position(opc == OP_INSERT_AT), pick_value());
               end
            end
         endcase
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() != 0 || req_if.valid) @(posedge clock);
      @(negedge clock);
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d transactions, peak occupancy %0d of %0d, %0d mismatches",
               accepted, peak_held, CAPACITY, mismatches);
      $display("Status mix ok/range/full/not-found: %0d/%0d/%0d/%0d",
               status_seen[STAT_OK], status_seen[STAT_RANGE],
               status_seen[STAT_FULL], status_seen[STAT_MISSING]);
      if (mismatches == 0 && pending_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
